// ===== rtl/japanese_encoding_guesser_core_defines.svh =====
// Assertion macros for the guesser RTL.
// Expects signals named clock and reset in the module that uses them.
`ifndef JAPANESE_ENCODING_GUESSER_CORE_DEFINES_SVH
`define JAPANESE_ENCODING_GUESSER_CORE_DEFINES_SVH
// Condition and consequence in the same cycle, checked outside reset.
`define JEG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequence in the cycle after the condition, checked outside reset.
`define JEG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/jeg_pkg.sv =====
// Shared types, constants and escape designation tables of the guesser.
// No dependencies; used by every RTL module.
`default_nettype none

package jeg_pkg;

   localparam int QUEUE_DEPTH  = 4;
   localparam int HOLD_DEPTH   = 4;   // bytes held after ESC
   localparam int REPLAY_DEPTH = HOLD_DEPTH + 1;
   localparam int NUM_PAT      = 8;
   localparam int PAT_MAX      = HOLD_DEPTH + 1;

   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ESC_CNT_W  = $clog2(HOLD_DEPTH + 2);
   localparam int HOLD_IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int REP_CNT_W  = $clog2(REPLAY_DEPTH + 1);
   localparam int REP_IDX_W  = $clog2(REPLAY_DEPTH);

   typedef logic [QPTR_W-1:0]     q_ptr_type;
   typedef logic [QCNT_W-1:0]     q_cnt_type;
   typedef logic [ESC_CNT_W-1:0]  esc_cnt_type;
   typedef logic [HOLD_IDX_W-1:0] hold_idx_type;
   typedef logic [REP_CNT_W-1:0]  rep_cnt_type;
   typedef logic [REP_IDX_W-1:0]  rep_idx_type;

   localparam logic [7:0] ESC_BYTE = 8'h1b;
   localparam logic [7:0] SO_BYTE  = 8'h0e;
   localparam logic [7:0] SI_BYTE  = 8'h0f;
   localparam logic [7:0] SS2_BYTE = 8'h8e;
   localparam logic [7:0] SS3_BYTE = 8'h8f;

   // Configuration register indexes
   localparam logic CSR_EXTENDED_RANGES = 1'b0;
   localparam logic CSR_FULLWIDTH_ONLY  = 1'b1;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_ESC,
      KIND_SO,
      KIND_SI
   } byte_kind_type;

   typedef enum logic [1:0] {
      MODE_ASCII     = 2'd0,
      MODE_KANJI     = 2'd1,
      MODE_SHIFT_OUT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_REJECT = 2'd0,
      PH_FIRST  = 2'd1,
      PH_NEXT   = 2'd2
   } phase_type;

   typedef struct packed {
      logic extended;
      logic fullwidth_only;
   } cfg_type;

   typedef struct packed {
      logic [7:0]    data;
      logic          last;
      byte_kind_type kind;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      phase_type  euc;
      phase_type  dec;
      phase_type  sjis;
      logic       no_fullwidth;
      logic [1:0] seen;   // bit0 jis, bit1 non-ascii
   } check_type;

   typedef struct packed {
      logic       jis_found;
      logic       nonascii_found;
      logic       euc_ok;
      logic       dec_ok;
      logic       sjis_ok;
      logic       jis8_too;
      logic [1:0] shift_mode;
      logic [1:0] kanji_in_marks;
      logic [3:0] kanji_out_marks;
      logic       new_kanji_mark;
      logic       gaiji_mark;
   } result_type;

   // Designation sequences, bytes after ESC
   localparam logic [7:0] PAT_TEXT [NUM_PAT][PAT_MAX] = '{
      '{8'h24, 8'h42, 8'h00, 8'h00, 8'h00},   // $ B
      '{8'h24, 8'h40, 8'h00, 8'h00, 8'h00},   // $ @
      '{8'h26, 8'h40, 8'h1b, 8'h24, 8'h42},   // & @ ESC $ B
      '{8'h28, 8'h42, 8'h00, 8'h00, 8'h00},   // ( B
      '{8'h28, 8'h4a, 8'h00, 8'h00, 8'h00},   // ( J
      '{8'h28, 8'h48, 8'h00, 8'h00, 8'h00},   // ( H
      '{8'h28, 8'h49, 8'h00, 8'h00, 8'h00},   // ( I
      '{8'h24, 8'h28, 8'h44, 8'h00, 8'h00}    // $ ( D
   };
   localparam esc_cnt_type PAT_LEN [NUM_PAT] = '{
      esc_cnt_type'(2), esc_cnt_type'(2), esc_cnt_type'(5), esc_cnt_type'(2),
      esc_cnt_type'(2), esc_cnt_type'(2), esc_cnt_type'(2), esc_cnt_type'(3)
   };
   localparam mode_type PAT_MODE [NUM_PAT] = '{
      MODE_KANJI, MODE_KANJI, MODE_KANJI, MODE_ASCII,
      MODE_ASCII, MODE_ASCII, MODE_KANJI, MODE_KANJI
   };
   localparam logic [7:0] PAT_MARK [NUM_PAT] = '{
      8'h01, 8'h02, 8'h40, 8'h04, 8'h08, 8'h10, 8'h20, 8'h80
   };

   function automatic byte_kind_type classify(input logic [7:0] b);
      byte_kind_type k;
      case (b)
         ESC_BYTE: k = KIND_ESC;
         SO_BYTE:  k = KIND_SO;
         SI_BYTE:  k = KIND_SI;
         default:  k = KIND_PLAIN;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/jeg_front.sv =====
// Front end: accepts request beats, tags control bytes and queues them.
// Depends on jeg_pkg.
`default_nettype none

`include "japanese_encoding_guesser_core_defines.svh"

module jeg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_in_buffer,
   input  logic              pop,
   output jeg_pkg::head_type head
);

   jeg_pkg::item_type  mem_ff [jeg_pkg::QUEUE_DEPTH];
   jeg_pkg::item_type  item;
   jeg_pkg::q_ptr_type wr_ptr_ff, wr_ptr_in;
   jeg_pkg::q_ptr_type rd_ptr_ff, rd_ptr_in;
   jeg_pkg::q_cnt_type count_ff, count_in;
   logic               push;

   function automatic jeg_pkg::q_ptr_type advance(input jeg_pkg::q_ptr_type p);
      jeg_pkg::q_ptr_type r;
      if (p == jeg_pkg::q_ptr_type'(jeg_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      req_ready = (count_ff != jeg_pkg::q_cnt_type'(jeg_pkg::QUEUE_DEPTH));
      push      = req_valid && req_ready;
      item.data = req_data_byte;
      item.last = req_last_in_buffer;
      item.kind = jeg_pkg::classify(req_data_byte);
      wr_ptr_in = push ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + jeg_pkg::q_cnt_type'(push) - jeg_pkg::q_cnt_type'(pop);
      head.valid = (count_ff != '0);
      head.item  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

   `JEG_ASSERT_SAME(a_q_bound, 1'b1, count_ff <= jeg_pkg::q_cnt_type'(jeg_pkg::QUEUE_DEPTH), "queue count over depth")
   `JEG_ASSERT_SAME(a_q_pop_empty, pop, count_ff != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/jeg_back.sv =====
// Back end: escape matching with replay, JIS mode, EUC/DEC/SJIS checks
// and the result register. Depends on jeg_pkg.
`default_nettype none

`include "japanese_encoding_guesser_core_defines.svh"

module jeg_back (
   input  logic                clock,
   input  logic                reset,
   input  jeg_pkg::cfg_type    cfg,
   input  jeg_pkg::head_type   head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output jeg_pkg::result_type rsp_result
);

   localparam jeg_pkg::esc_cnt_type ESC_MAX = jeg_pkg::esc_cnt_type'(jeg_pkg::HOLD_DEPTH + 1);
   localparam jeg_pkg::rep_cnt_type REP_MAX = jeg_pkg::rep_cnt_type'(jeg_pkg::REPLAY_DEPTH);

   jeg_pkg::mode_type    mode_ff, mode_in;
   jeg_pkg::check_type   chk_ff, chk_in;
   logic [7:0]           prior_ff, prior_in;
   logic [7:0]           hold_ff [jeg_pkg::HOLD_DEPTH];
   logic [7:0]           hold_in [jeg_pkg::HOLD_DEPTH];
   jeg_pkg::esc_cnt_type esc_cnt_ff, esc_cnt_in;
   logic [7:0]           marks_ff, marks_in;
   logic [7:0]           rep_ff [jeg_pkg::REPLAY_DEPTH];
   logic [7:0]           rep_in [jeg_pkg::REPLAY_DEPTH];
   jeg_pkg::rep_cnt_type rep_cnt_ff, rep_cnt_in;
   logic                 item_last_ff, item_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   jeg_pkg::result_type  rsp_res_ff, res;

   logic                  src_rep, src_fin, src_fifo, cur_last, out_busy, go, emit;
   logic [7:0]            cur;
   jeg_pkg::byte_kind_type cur_kind;
   logic [7:0]            rem [jeg_pkg::REPLAY_DEPTH];
   jeg_pkg::rep_cnt_type  rem_cnt, tail_len;
   logic [7:0]            cand [jeg_pkg::PAT_MAX];
   logic [jeg_pkg::NUM_PAT-1:0] fit, full;
   logic                  any_fit, any_full, differs, mism, mism_cur;
   logic [2:0]            full_idx;
   jeg_pkg::check_type    ex_cur, ex_esc;

   // One byte through the three code checks
   function automatic jeg_pkg::check_type examine(
      input jeg_pkg::check_type s,
      input logic [7:0]         c,
      input logic [7:0]         p,
      input jeg_pkg::cfg_type   k
   );
      jeg_pkg::check_type r;
      logic [7:0] lo;
      logic [7:0] kana_top;
      logic [7:0] sj_top;
      r        = s;
      lo       = {1'b0, c[6:0]};
      kana_top = k.extended ? 8'hff : 8'he0;
      sj_top   = k.extended ? 8'hfc : 8'hef;
      if (c[7]) begin
         r.seen[1] = 1'b1;
      end
      case (s.euc)
         jeg_pkg::PH_FIRST: begin
            if (c[7]) begin
               if ((c > 8'ha0 && c < 8'hff) ||
                   (!k.fullwidth_only && c == jeg_pkg::SS2_BYTE)) begin
                  r.euc = jeg_pkg::PH_NEXT;
               end else if (k.extended && c == jeg_pkg::SS3_BYTE) begin
                  r.euc = jeg_pkg::PH_NEXT;
               end else if (!(k.extended && c < 8'ha0)) begin
                  r.euc = jeg_pkg::PH_REJECT;
               end
            end
         end
         jeg_pkg::PH_NEXT: begin
            if (p == jeg_pkg::SS2_BYTE) begin
               r.euc = (c > 8'ha0 && c < kana_top) ? jeg_pkg::PH_FIRST : jeg_pkg::PH_REJECT;
            end else if (c > 8'ha0 && c < 8'hff) begin
               // after SS3 the next byte is still due
               if (p != jeg_pkg::SS3_BYTE) begin
                  r.euc = jeg_pkg::PH_FIRST;
               end
            end else begin
               r.euc = jeg_pkg::PH_REJECT;
            end
         end
         default: ;
      endcase
      if (k.extended) begin
         case (s.dec)
            jeg_pkg::PH_FIRST: begin
               if (c[7]) begin
                  if (c > 8'ha0 && c < 8'hff) begin
                     r.dec = jeg_pkg::PH_NEXT;
                  end else if (c >= 8'ha0) begin
                     r.dec = jeg_pkg::PH_REJECT;
                  end
               end
            end
            jeg_pkg::PH_NEXT: begin
               r.dec = (lo > 8'h20 && lo < 8'h7f) ? jeg_pkg::PH_FIRST : jeg_pkg::PH_REJECT;
            end
            default: ;
         endcase
      end
      case (s.sjis)
         jeg_pkg::PH_FIRST: begin
            if (c[7]) begin
               if (c > 8'ha0 && c < 8'he0) begin
                  if (k.fullwidth_only) begin
                     r.sjis = jeg_pkg::PH_REJECT;
                  end
               end else if (c != 8'h80 && c != 8'ha0 && c <= sj_top) begin
                  r.sjis         = jeg_pkg::PH_NEXT;
                  r.no_fullwidth = 1'b0;
               end else begin
                  r.sjis = jeg_pkg::PH_REJECT;
               end
            end
         end
         jeg_pkg::PH_NEXT: begin
            r.sjis = (c >= 8'h40 && c != 8'h7f && c <= 8'hfc) ?
                     jeg_pkg::PH_FIRST : jeg_pkg::PH_REJECT;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Source select: replay first, then a pending final mismatch, then the queue
   always_comb begin
      src_rep  = (rep_cnt_ff != '0);
      src_fin  = !src_rep && item_last_ff && (esc_cnt_ff != '0);
      src_fifo = !src_rep && !src_fin && head.valid;
      cur_last = src_fifo ? head.item.last : item_last_ff;
      out_busy = rsp_valid_ff && !rsp_ready;
      go       = (src_rep || src_fin || src_fifo) && !(cur_last && out_busy);
      pop      = go && src_fifo;
      cur      = src_rep ? rep_ff[0] : head.item.data;
      cur_kind = src_rep ? jeg_pkg::classify(rep_ff[0]) : head.item.kind;
      for (int i = 0; i < jeg_pkg::REPLAY_DEPTH - 1; i++) begin
         rem[i] = rep_ff[i+1];
      end
      rem[jeg_pkg::REPLAY_DEPTH-1] = 8'h00;
      rem_cnt = src_rep ? rep_cnt_ff - 1'b1 : '0;
      ex_cur  = examine(chk_ff, cur, prior_ff, cfg);
      ex_esc  = examine(chk_ff, jeg_pkg::ESC_BYTE, prior_ff, cfg);
   end

   // Compare held bytes plus the current byte against every designation
   always_comb begin
      for (int i = 0; i < jeg_pkg::PAT_MAX; i++) begin
         if (i < jeg_pkg::HOLD_DEPTH &&
             jeg_pkg::esc_cnt_type'(i + 1) < esc_cnt_ff) begin
            cand[i] = hold_ff[jeg_pkg::hold_idx_type'(i)];
         end else begin
            cand[i] = cur;
         end
      end
      for (int k = 0; k < jeg_pkg::NUM_PAT; k++) begin
         differs = 1'b0;
         for (int i = 0; i < jeg_pkg::PAT_MAX; i++) begin
            if (jeg_pkg::esc_cnt_type'(i) < esc_cnt_ff &&
                cand[i] != jeg_pkg::PAT_TEXT[k][i]) begin
               differs = 1'b1;
            end
         end
         fit[k]  = (jeg_pkg::PAT_LEN[k] >= esc_cnt_ff) && !differs;
         full[k] = fit[k] && (jeg_pkg::PAT_LEN[k] == esc_cnt_ff);
      end
      any_fit  = |fit;
      any_full = |full;
      full_idx = '0;
      for (int k = jeg_pkg::NUM_PAT - 1; k >= 0; k--) begin
         if (full[k]) begin
            full_idx = 3'(k);
         end
      end
   end

   // Next state for one processed byte
   always_comb begin
      mode_in      = mode_ff;
      chk_in       = chk_ff;
      prior_in     = prior_ff;
      hold_in      = hold_ff;
      esc_cnt_in   = esc_cnt_ff;
      marks_in     = marks_ff;
      rep_in       = rep_ff;
      rep_cnt_in   = rep_cnt_ff;
      item_last_in = item_last_ff;
      mism         = 1'b0;
      mism_cur     = 1'b0;
      tail_len     = '0;
      if (pop) begin
         item_last_in = head.item.last;
      end
      if (go) begin
         rep_in     = rem;
         rep_cnt_in = rem_cnt;
         if (src_fin) begin
            mism = 1'b1;
         end else if (esc_cnt_ff != '0) begin
            if (any_full) begin
               mode_in    = jeg_pkg::PAT_MODE[full_idx];
               marks_in   = marks_ff | jeg_pkg::PAT_MARK[full_idx];
               esc_cnt_in = '0;
               if (mode_ff == jeg_pkg::MODE_ASCII) begin
                  chk_in = ex_esc;
               end
               chk_in.seen[0] = 1'b1;
               prior_in       = cur;
            end else if (any_fit && esc_cnt_ff < ESC_MAX) begin
               hold_in[jeg_pkg::hold_idx_type'(esc_cnt_ff - 1'b1)] = cur;
               esc_cnt_in = esc_cnt_ff + 1'b1;
            end else begin
               mism     = 1'b1;
               mism_cur = 1'b1;
            end
         end else begin
            case (cur_kind)
               jeg_pkg::KIND_ESC: begin
                  // skipped in shift-out, otherwise opens a sequence
                  if (mode_ff == jeg_pkg::MODE_SHIFT_OUT) begin
                     prior_in = cur;
                  end else begin
                     esc_cnt_in = jeg_pkg::esc_cnt_type'(1);
                  end
               end
               jeg_pkg::KIND_SO: begin
                  if (mode_ff == jeg_pkg::MODE_ASCII) begin
                     chk_in         = ex_cur;
                     chk_in.seen[0] = 1'b1;
                     mode_in        = jeg_pkg::MODE_SHIFT_OUT;
                  end
                  prior_in = cur;
               end
               jeg_pkg::KIND_SI: begin
                  if (mode_ff == jeg_pkg::MODE_SHIFT_OUT) begin
                     mode_in = jeg_pkg::MODE_ASCII;
                  end else if (mode_ff == jeg_pkg::MODE_ASCII) begin
                     chk_in = ex_cur;
                  end
                  prior_in = cur;
               end
               default: begin
                  if (mode_ff == jeg_pkg::MODE_ASCII) begin
                     chk_in = ex_cur;
                  end
                  prior_in = cur;
               end
            endcase
         end
         if (mism) begin
            // drop the sequence: ESC goes to the checks, held bytes replay
            esc_cnt_in = '0;
            chk_in     = ex_esc;
            prior_in   = jeg_pkg::ESC_BYTE;
            tail_len   = jeg_pkg::rep_cnt_type'(esc_cnt_ff - 1'b1) +
                         jeg_pkg::rep_cnt_type'(mism_cur);
            for (int i = 0; i < jeg_pkg::REPLAY_DEPTH; i++) begin
               if (i < jeg_pkg::HOLD_DEPTH &&
                   jeg_pkg::esc_cnt_type'(i + 1) < esc_cnt_ff) begin
                  rep_in[i] = hold_ff[jeg_pkg::hold_idx_type'(i)];
               end else if (mism_cur && jeg_pkg::esc_cnt_type'(i + 1) == esc_cnt_ff) begin
                  rep_in[i] = cur;
               end else if (jeg_pkg::rep_cnt_type'(i) >= tail_len) begin
                  rep_in[i] = rem[jeg_pkg::rep_idx_type'(jeg_pkg::rep_cnt_type'(i) - tail_len)];
               end else begin
                  rep_in[i] = rem[0];
               end
            end
            rep_cnt_in = tail_len + rem_cnt;
         end
      end

      emit = go && cur_last && (rep_cnt_in == '0) && (esc_cnt_in == '0);

      res.jis_found       = chk_in.seen[0];
      res.nonascii_found  = chk_in.seen[1];
      res.euc_ok          = (chk_in.euc == jeg_pkg::PH_FIRST);
      res.dec_ok          = cfg.extended && (chk_in.dec == jeg_pkg::PH_FIRST);
      res.sjis_ok         = (chk_in.sjis == jeg_pkg::PH_FIRST);
      res.jis8_too        = res.sjis_ok && !cfg.fullwidth_only && chk_in.no_fullwidth;
      res.shift_mode      = mode_in;
      res.kanji_in_marks  = marks_in[1:0];
      res.kanji_out_marks = marks_in[5:2];
      res.new_kanji_mark  = marks_in[6];
      res.gaiji_mark      = marks_in[7];

      if (emit) begin
         // restart per-buffer checks
         chk_in.euc          = jeg_pkg::PH_FIRST;
         chk_in.dec          = jeg_pkg::PH_FIRST;
         chk_in.sjis         = jeg_pkg::PH_FIRST;
         chk_in.no_fullwidth = 1'b1;
         chk_in.seen         = '0;
         prior_in            = 8'h00;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff             <= jeg_pkg::MODE_ASCII;
         chk_ff.euc          <= jeg_pkg::PH_FIRST;
         chk_ff.dec          <= jeg_pkg::PH_FIRST;
         chk_ff.sjis         <= jeg_pkg::PH_FIRST;
         chk_ff.no_fullwidth <= 1'b1;
         chk_ff.seen         <= '0;
         prior_ff            <= 8'h00;
         esc_cnt_ff          <= '0;
         marks_ff            <= 8'h00;
         rep_cnt_ff          <= '0;
         item_last_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         chk_ff       <= chk_in;
         prior_ff     <= prior_in;
         esc_cnt_ff   <= esc_cnt_in;
         marks_ff     <= marks_in;
         rep_cnt_ff   <= rep_cnt_in;
         item_last_ff <= item_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rep_ff  <= rep_in;
      if (emit) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_res_ff;

   `JEG_ASSERT_SAME(a_rep_bound, 1'b1, rep_cnt_ff <= REP_MAX, "replay queue overrun")
   `JEG_ASSERT_SAME(a_pop_idle, pop, (rep_cnt_ff == '0) && !(item_last_ff && (esc_cnt_ff != '0)), "queue popped while a byte is in flight")
   `JEG_ASSERT_NEXT(a_emit_clean, emit, (esc_cnt_ff == '0) && (rep_cnt_ff == '0) && (chk_ff.seen == '0), "buffer end left state behind")

endmodule

`default_nettype wire

// ===== rtl/japanese_encoding_guesser_core.sv =====
// Top level of the Japanese text encoding guesser.
// Depends on jeg_pkg, jeg_front and jeg_back.
`default_nettype none

// Feed a text buffer one byte per request beat, with req_last_in_buffer set
// on its final byte; that byte yields one response beat carrying the JIS,
// EUC, DEC and Shift-JIS verdicts, the JIS shift mode left after the
// buffer, and the designation marks, which accumulate from reset. Other
// bytes yield nothing. Beats enter a four-deep queue, so the request side
// keeps flowing while a response waits, until the queue is full. The back
// end takes one byte per clock from the queue while not replaying or stalled.
// An ESC sequence that turns out not to be a designation passes its ESC to
// the checks, then replays the bytes held behind it (at most four) and the
// byte that broke the match; a replayed byte may open a sequence of its own.
// A sequence left open by the last byte is flushed the same way before the
// response. A last byte also waits while an earlier response is still held.
// rsp_valid is registered, set when the back end finishes the buffer. The
// CSR registers (index 0 extended ranges, index 1 fullwidth only) are plain
// write-only bits; write them only while no buffer is in progress.
module japanese_encoding_guesser_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in_buffer,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_jis_found,
   output logic       rsp_nonascii_found,
   output logic       rsp_euc_ok,
   output logic       rsp_dec_ok,
   output logic       rsp_sjis_ok,
   output logic       rsp_jis8_too,
   output logic [1:0] rsp_shift_mode,
   output logic [1:0] rsp_kanji_in_marks,
   output logic [3:0] rsp_kanji_out_marks,
   output logic       rsp_new_kanji_mark,
   output logic       rsp_gaiji_mark,
   // configuration write port
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   jeg_pkg::cfg_type    cfg_ff;
   jeg_pkg::head_type   head;
   jeg_pkg::result_type result;
   logic                pop;

   // Hold the configuration bits; write them on csr_we
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            jeg_pkg::CSR_EXTENDED_RANGES: cfg_ff.extended       <= csr_wdata;
            jeg_pkg::CSR_FULLWIDTH_ONLY:  cfg_ff.fullwidth_only <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front: accept beats, tag ESC/SO/SI, queue
   jeg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_in_buffer (req_last_in_buffer),
      .pop                (pop),
      .head               (head)
   );

   // Back: match designations, replay on mismatch, run the checks
   jeg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   // Break the result register out into the response fields
   assign rsp_jis_found       = result.jis_found;
   assign rsp_nonascii_found  = result.nonascii_found;
   assign rsp_euc_ok          = result.euc_ok;
   assign rsp_dec_ok          = result.dec_ok;
   assign rsp_sjis_ok         = result.sjis_ok;
   assign rsp_jis8_too        = result.jis8_too;
   assign rsp_shift_mode      = result.shift_mode;
   assign rsp_kanji_in_marks  = result.kanji_in_marks;
   assign rsp_kanji_out_marks = result.kanji_out_marks;
   assign rsp_new_kanji_mark  = result.new_kanji_mark;
   assign rsp_gaiji_mark      = result.gaiji_mark;

endmodule

`default_nettype wire
